>>> rtl/swr_pkg.sv
// Shared types and constants for the sliding window receiver.
// Field widths, configuration register indexes and register reset values.
// No dependencies; compiled first.
package swr_pkg;

  localparam int SEQ_NUM_W  = 16;
  localparam int ACK_SEQ_W  = 16;
  localparam int SLOT_W     = 5;
  localparam int DELIV_W    = 6;
  localparam int RANGE_W    = 16;
  localparam int WSIZE_W    = 6;
  localparam int SWIN_W     = 16;
  localparam int CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [RANGE_W-1:0] SEQ_MOD_RST       = 16'd16;
  localparam logic [WSIZE_W-1:0] RX_SLOTS_RST      = 6'd8;
  localparam logic               GBN_MODE_RST      = 1'b0;
  localparam logic [SWIN_W-1:0]  SENDER_WINDOW_RST = 16'd8;

  typedef enum logic [1:0] {
    CFG_SEQ_MOD       = 2'd0,
    CFG_RX_SLOTS      = 2'd1,
    CFG_GBN_MODE      = 2'd2,
    CFG_SENDER_WINDOW = 2'd3
  } cfg_idx_t;

endpackage

>>> rtl/swr_if.sv
// Valid/ready channel interfaces for the sliding window receiver.
// swr_in_if carries packet headers, swr_out_if carries per-packet results.
// Depends on swr_pkg for the field widths.
interface swr_in_if;
  import swr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SEQ_NUM_W-1:0] seq_num;
  logic                 ack_requested;

  modport source (output valid, output seq_num, output ack_requested, input ready);
  modport sink   (input valid, input seq_num, input ack_requested, output ready);
endinterface

interface swr_out_if;
  import swr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ack_valid;
  logic [ACK_SEQ_W-1:0] ack_seq;
  logic                 accepted;
  logic [SLOT_W-1:0]    slot;
  logic                 duplicate;
  logic [DELIV_W-1:0]   delivered;

  modport source (output valid, output ack_valid, output ack_seq, output accepted,
                  output slot, output duplicate, output delivered, input ready);
  modport sink   (input valid, input ack_valid, input ack_seq, input accepted,
                  input slot, input duplicate, input delivered, output ready);
endinterface

>>> rtl/sliding_window_receiver.sv
// Top level of the ARQ sliding window receiver (go-back-N or selective repeat).
// Depends on swr_pkg and on the channel interfaces in swr_if.sv.
//
// Usage: packet headers (seq_num, ack_requested) arrive on in_port, one per
// transfer. For every header exactly one result leaves on out_port: whether
// to acknowledge and with which number, whether the payload goes to a slot
// and which one, whether the packet was a duplicate, and how many in-order
// slots were released. A header is held in the input register and is
// evaluated against the window state on its way to the output register,
// from which its result is offered. The window update is a single pass
// through short logic, so one header is taken every cycle as long as
// the result in the output register is not held back by the consumer.
// When the consumer holds out_port.ready low, the result stays put, one
// more header may still be taken into the input register, and after that
// in_port.ready drops until the output moves. The configuration port writes
// one register per cycle; each write also restarts the window with the new
// values: base zero, end at slot count (go-back-N: sender window) minus one,
// no slot received. Reset, synchronous and active low, restores register
// defaults, restarts the window alike and empties both pipeline registers.
module sliding_window_receiver #(
  parameter int MAX_WINDOW = 32,
  parameter int SEQ_WIDTH  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  swr_in_if.sink                          in_port,
  swr_out_if.source                       out_port,
  input  logic                            cfg_wr_en,
  input  swr_pkg::cfg_idx_t               cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import swr_pkg::*;

  // Working width for sequence arithmetic: wide enough for both the 16-bit
  // header fields and SEQ_WIDTH state, with room for a sum and a sign.
  localparam int XW = ((SEQ_WIDTH > 16) ? SEQ_WIDTH : 16) + 2;
  // Width of a slot count or a delivered run (0 .. MAX_WINDOW).
  localparam int NW = $clog2(MAX_WINDOW + 1);
  // Width of a slot index into the received bitmap.
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Configuration registers.
  logic [RANGE_W-1:0] seq_mod_r,       seq_mod_nxt;
  logic [WSIZE_W-1:0] rx_slots_r,      rx_slots_nxt;
  logic               gbn_mode_r,      gbn_mode_nxt;
  logic [SWIN_W-1:0]  sender_window_r, sender_window_nxt;

  // Window state.
  logic [SEQ_WIDTH-1:0]  base_r, base_nxt;
  logic [SEQ_WIDTH-1:0]  end_r,  end_nxt;
  logic [MAX_WINDOW-1:0] map_r,  map_nxt;
  logic [SEQ_WIDTH-1:0]  end_init;

  // Input register.
  logic                 in_v_r;
  logic [SEQ_NUM_W-1:0] seq_r;
  logic                 ack_req_r;

  // Output register.
  logic                 out_v_r;
  logic                 ack_valid_r, ack_valid_nxt;
  logic [ACK_SEQ_W-1:0] ack_seq_r,   ack_seq_nxt;
  logic                 accepted_r,  accepted_nxt;
  logic [SLOT_W-1:0]    slot_r,      slot_nxt;
  logic                 duplicate_r, duplicate_nxt;
  logic [DELIV_W-1:0]   delivered_r, delivered_nxt;

  logic step;

  // Number of active slots: one in go-back-N, else the configured slot count
  // clamped to the range 1 .. MAX_WINDOW.
  function automatic logic [NW-1:0] slot_count(input logic gbn,
                                               input logic [WSIZE_W-1:0] ws);
    logic [NW-1:0] n;
    if (gbn) begin
      n = NW'(1);
    end else if (ws == '0) begin
      n = NW'(1);
    end else if (7'(ws) > 7'(MAX_WINDOW)) begin
      n = NW'(MAX_WINDOW);
    end else begin
      n = NW'(ws);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration. The next values double as the source of the window
  // restart, so a write and its restart happen at the same edge.
  // ---------------------------------------------------------------------
  always_comb begin
    seq_mod_nxt       = seq_mod_r;
    rx_slots_nxt      = rx_slots_r;
    gbn_mode_nxt      = gbn_mode_r;
    sender_window_nxt = sender_window_r;
    if (!rst_n) begin
      seq_mod_nxt       = SEQ_MOD_RST;
      rx_slots_nxt      = RX_SLOTS_RST;
      gbn_mode_nxt      = GBN_MODE_RST;
      sender_window_nxt = SENDER_WINDOW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEQ_MOD:       seq_mod_nxt       = cfg_wdata[RANGE_W-1:0];
        CFG_RX_SLOTS:      rx_slots_nxt      = cfg_wdata[WSIZE_W-1:0];
        CFG_GBN_MODE:      gbn_mode_nxt      = cfg_wdata[0];
        CFG_SENDER_WINDOW: sender_window_nxt = cfg_wdata[SWIN_W-1:0];
        default:           seq_mod_nxt       = seq_mod_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    seq_mod_r       <= seq_mod_nxt;
    rx_slots_r      <= rx_slots_nxt;
    gbn_mode_r      <= gbn_mode_nxt;
    sender_window_r <= sender_window_nxt;
  end

  // Initial window end: sender window minus one in go-back-N, otherwise
  // the slot count minus one, both wrapped to SEQ_WIDTH bits.
  always_comb begin
    logic [XW-1:0] sw_m1;
    logic [NW-1:0] n_init;
    sw_m1  = XW'(sender_window_nxt) - XW'(1);
    n_init = slot_count(gbn_mode_nxt, rx_slots_nxt) - NW'(1);
    if (gbn_mode_nxt) begin
      end_init = sw_m1[SEQ_WIDTH-1:0];
    end else begin
      end_init = SEQ_WIDTH'(n_init);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake. The header in the input register moves on whenever the
  // output register is empty or being drained.
  // ---------------------------------------------------------------------
  assign step          = in_v_r && (!out_v_r || out_port.ready);
  assign in_port.ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_port.ready) begin
        in_v_r <= in_port.valid;
      end
      if (step) begin
        out_v_r <= 1'b1;
      end else if (out_port.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_port.valid && in_port.ready) begin
      seq_r     <= in_port.seq_num;
      ack_req_r <= in_port.ack_requested;
    end
  end

  // ---------------------------------------------------------------------
  // Window evaluation for the header in the input register.
  // ---------------------------------------------------------------------
  always_comb begin
    logic signed [XW:0]    b_s, e_s, s_s, r_s, n_s, off;
    logic [NW-1:0]         n;
    logic [NW-1:0]         run;
    logic [IW-1:0]         idx;
    logic                  off_neg, off_zero, in_win, hit;
    logic                  ack;
    logic [XW-1:0]         seq_x, bm1, bsum, esum;
    logic [MAX_WINDOW-1:0] map_upd, masked;

    n     = slot_count(gbn_mode_r, rx_slots_r);
    b_s   = $signed({1'b0, XW'(base_r)});
    e_s   = $signed({1'b0, XW'(end_r)});
    s_s   = $signed({1'b0, XW'(seq_r)});
    r_s   = $signed({1'b0, XW'(seq_mod_r)});
    n_s   = $signed({1'b0, XW'(n)});
    seq_x = XW'(seq_r);
    bm1   = XW'(base_r) - XW'(1);

    // Slot offset. With base above end the window has wrapped, and a
    // sequence number at or below end is counted past the wrap point.
    if (b_s == e_s) begin
      off = '0;
    end else if ((b_s < e_s) || (s_s > e_s)) begin
      off = s_s - b_s;
    end else begin
      off = r_s - b_s + s_s;
    end
    off_neg  = off[XW];
    off_zero = (off == '0);
    in_win   = !off_neg && (off < n_s);
    idx      = off[IW-1:0];
    hit      = in_win ? map_r[idx] : 1'b0;

    map_upd       = map_r;
    ack           = 1'b0;
    ack_seq_nxt   = '0;
    accepted_nxt  = 1'b0;
    slot_nxt      = '0;
    duplicate_nxt = 1'b0;

    if (gbn_mode_r) begin
      // Single slot: only the expected number is taken; anything older is
      // acked with its own number, anything ahead with the last good one (none while base is zero).
      priority if (off_neg) begin
        map_upd[0]    = 1'b0;
        ack           = 1'b1;
        ack_seq_nxt   = 16'(seq_x);
        duplicate_nxt = 1'b1;
      end else if (off_zero) begin
        map_upd[0]   = 1'b1;
        ack          = 1'b1;
        ack_seq_nxt  = 16'(seq_x);
        accepted_nxt = 1'b1;
      end else if (base_r == '0) begin
        duplicate_nxt = 1'b1;
      end else begin
        map_upd[0]  = 1'b0;
        ack         = 1'b1;
        ack_seq_nxt = 16'(bm1[SEQ_WIDTH-1:0]);
      end
    end else begin
      priority if (!in_win || hit) begin
        duplicate_nxt = 1'b1;
      end else begin
        map_upd[idx] = 1'b1;
        ack          = 1'b1;
        ack_seq_nxt  = 16'(seq_x);
        accepted_nxt = 1'b1;
        slot_nxt     = SLOT_W'(off);
      end
    end

    // Keep only active slots, then release the leading run of received ones.
    for (int i = 0; i < MAX_WINDOW; i++) begin
      masked[i] = map_upd[i] && (NW'(i) < n);
    end
    run = NW'(MAX_WINDOW);
    for (int i = MAX_WINDOW - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        run = NW'(i);
      end
    end
    map_nxt = masked >> run;

    bsum = XW'(base_r) + XW'(run);
    if (bsum >= XW'(seq_mod_r)) begin
      bsum = bsum - XW'(seq_mod_r);
    end
    esum = XW'(end_r) + XW'(run);
    if (esum >= XW'(seq_mod_r)) begin
      esum = esum - XW'(seq_mod_r);
    end
    base_nxt = bsum[SEQ_WIDTH-1:0];
    end_nxt  = esum[SEQ_WIDTH-1:0];

    // An acknowledgement goes out only if the sender asked for one.
    ack_valid_nxt = ack && ack_req_r;
    if (!ack_valid_nxt) begin
      ack_seq_nxt = '0;
    end
    delivered_nxt = DELIV_W'(run);
  end

  // Window state: reset and every configuration write restart the window.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      base_r <= '0;
      end_r  <= end_init;
      map_r  <= '0;
    end else if (step) begin
      base_r <= base_nxt;
      end_r  <= end_nxt;
      map_r  <= map_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ack_valid_r <= ack_valid_nxt;
      ack_seq_r   <= ack_seq_nxt;
      accepted_r  <= accepted_nxt;
      slot_r      <= slot_nxt;
      duplicate_r <= duplicate_nxt;
      delivered_r <= delivered_nxt;
    end
  end

  assign out_port.valid     = out_v_r;
  assign out_port.ack_valid = ack_valid_r;
  assign out_port.ack_seq   = ack_seq_r;
  assign out_port.accepted  = accepted_r;
  assign out_port.slot      = slot_r;
  assign out_port.duplicate = duplicate_r;
  assign out_port.delivered = delivered_r;

endmodule

>>> rtl/swr_checker.sv
// Port-level assertions for the sliding window receiver.
// Depends on swr_pkg; bound to sliding_window_receiver at the end of this file.
module swr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           ack_valid,
  input logic [swr_pkg::ACK_SEQ_W-1:0]  ack_seq,
  input logic                           accepted,
  input logic [swr_pkg::SLOT_W-1:0]     slot,
  input logic                           duplicate,
  input logic [swr_pkg::DELIV_W-1:0]    delivered
);
  import swr_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ack_seq) && $stable(slot)
      && $stable(delivered) && $stable(accepted) && $stable(ack_valid))
    else $error("stalled result changed");

  // Slots are only released when this packet filled the gap at the base.
  a_deliver_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (delivered != '0) |-> accepted)
    else $error("slots released without an accepted packet");

  // A stored packet is never flagged as a duplicate.
  a_accept_not_dup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && accepted |-> !duplicate)
    else $error("accepted packet marked duplicate");

  // Fields that do not apply read as zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ack_valid || (ack_seq == '0)) && (accepted || (slot == '0)))
    else $error("inactive result field not zero");

endmodule

bind sliding_window_receiver swr_checker u_swr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_port.valid),
  .out_ready (out_port.ready),
  .ack_valid (out_port.ack_valid),
  .ack_seq   (out_port.ack_seq),
  .accepted  (out_port.accepted),
  .slot      (out_port.slot),
  .duplicate (out_port.duplicate),
  .delivered (out_port.delivered)
);
